// ----- sv/fcp_tlv_parser_core_assert.svh -----
// Assertion macros shared by the parser RTL.
// Users must have clock and reset in scope; no other dependencies.
`ifndef FCP_TLV_PARSER_CORE_ASSERT_SVH
`define FCP_TLV_PARSER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define FCP_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define FCP_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/fcp_pkg.sv -----
// Shared types, constants and tag rule functions for the FCP TLV parser.
// No dependencies.
package fcp_pkg;

   localparam int MAX_FIELD_LEN_DEF = 20;
   localparam int QUEUE_DEPTH       = 4;

   localparam logic [7:0] OUTER_TAG = 8'h62;

   typedef enum logic [2:0] {
      PH_OUTER_TAG = 3'd0,
      PH_OUTER_LEN = 3'd1,
      PH_TAG       = 3'd2,
      PH_LEN       = 3'd3,
      PH_VALUE     = 3'd4,
      PH_DROP      = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      KIND_VALUE = 2'd0,
      KIND_OK    = 2'd1,
      KIND_FAIL  = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      CAUSE_NONE  = 3'd0,
      CAUSE_OUTER = 3'd1,
      CAUSE_TAG   = 3'd2,
      CAUSE_LEN   = 3'd3,
      CAUSE_TRUNC = 3'd4
   } cause_type;

   typedef enum logic [3:0] {
      FLD_SIZE     = 4'd0,
      FLD_DESC     = 4'd1,
      FLD_FILE_ID  = 4'd2,
      FLD_AID      = 4'd3,
      FLD_SHORT_ID = 4'd4,
      FLD_LIFE     = 4'd5,
      FLD_COMPACT  = 4'd6,
      FLD_ENV_ID   = 4'd7,
      FLD_EXPANDED = 4'd8
   } field_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       final_byte;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [3:0] field_code;
      logic [7:0] value;
      logic [4:0] offset;
      logic       field_end;
      logic [2:0] error_cause;
      logic       run_last;
   } rsp_type;

   // One queue entry: an optional value result followed by an optional status.
   typedef struct packed {
      logic       has_val;
      field_type  field_code;
      logic [7:0] value;
      logic [4:0] offset;
      logic       field_end;
      logic       has_stat;
      cause_type  cause;
   } entry_type;

   typedef struct packed {
      logic      found;
      field_type code;
   } lookup_type;

   function automatic lookup_type tag_lookup(input logic [7:0] tag);
      lookup_type r;
      r.found = 1'b1;
      case (tag)
         8'h80:   r.code = FLD_SIZE;
         8'h82:   r.code = FLD_DESC;
         8'h83:   r.code = FLD_FILE_ID;
         8'h84:   r.code = FLD_AID;
         8'h88:   r.code = FLD_SHORT_ID;
         8'h8A:   r.code = FLD_LIFE;
         8'h8C:   r.code = FLD_COMPACT;
         8'h8D:   r.code = FLD_ENV_ID;
         8'hAB:   r.code = FLD_EXPANDED;
         default: begin
            r.found = 1'b0;
            r.code  = FLD_SIZE;
         end
      endcase
      return r;
   endfunction

   function automatic logic rule_exact(input field_type code);
      logic r;
      case (code)
         FLD_SIZE, FLD_FILE_ID, FLD_SHORT_ID, FLD_LIFE, FLD_ENV_ID: r = 1'b1;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] rule_limit(input field_type code,
                                             input logic [7:0] max_len);
      logic [7:0] r;
      case (code)
         FLD_SIZE:     r = 8'd2;
         FLD_DESC:     r = 8'd5;
         FLD_FILE_ID:  r = 8'd2;
         FLD_AID:      r = 8'd16;
         FLD_SHORT_ID: r = 8'd1;
         FLD_LIFE:     r = 8'd1;
         FLD_COMPACT:  r = 8'd7;
         FLD_ENV_ID:   r = 8'd2;
         default:      r = max_len;
      endcase
      return r;
   endfunction

endpackage

// ----- sv/fcp_if.sv -----
// Valid/ready channel interfaces for the parser's input and result streams.
// Depends on fcp_pkg for the payload types.
interface fcp_req_if;
   import fcp_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface fcp_rsp_if;
   import fcp_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- sv/fcp_tlv_parser_core.sv -----
// Top level of the FCP TLV parser: front end, entry queue, result sequencer.
// Depends on fcp_pkg, fcp_if and the fcp_front / fcp_queue / fcp_back modules.
//
// Usage:
//   req_chan carries one template byte per item (data_byte) with final_byte set
//   on the template's last byte. rsp_chan returns result items: one per value
//   byte of a known field (kind value, field code, offset, field_end), plus an
//   ok or fail status after the final byte or at the first error. run_last
//   marks the last result an input byte produced. After an error, input bytes
//   are swallowed without results up to and including the final byte.
//   Throughput: one input byte per cycle while the queue is not full; the front
//   end's parse state machine settles each byte as it is accepted. The result
//   side drains one result per cycle while rsp_chan.ready is high, so a byte
//   with both a value and a status holds the output for both in turn. Path:
//   with no backlog, an accepted item is written into the queue, then loaded
//   into the output register that offers it on rsp_chan (one queue stage, one output register).
//   Stalls: when rsp_chan.ready is low the output register holds its item; the
//   four-entry queue keeps absorbing bytes and req_chan.ready drops only once
//   it fills. Bytes that produce no result never occupy the queue.
//   Reset (synchronous, active high) empties the queue and output register and
//   returns the parser to expecting the outer tag.
module fcp_tlv_parser_core #(
   parameter int MAX_FIELD_LEN = fcp_pkg::MAX_FIELD_LEN_DEF
) (
   input  logic      clock,
   input  logic      reset,
   fcp_req_if.sink   req_chan,
   fcp_rsp_if.source rsp_chan
);
   import fcp_pkg::*;

   logic      accept;
   logic      push;
   entry_type push_entry;
   logic      q_full;
   logic      q_not_empty;
   logic      q_pop;
   entry_type q_head;

   // front end only stalls when the queue is full
   assign req_chan.ready = !q_full;
   assign accept         = req_chan.valid && !q_full;

   fcp_front #(
      .MAX_FIELD_LEN (MAX_FIELD_LEN)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .data_byte  (req_chan.payload.data_byte),
      .final_byte (req_chan.payload.final_byte),
      .push       (push),
      .entry      (push_entry)
   );

   fcp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_entry),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   fcp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_chan.valid),
      .rsp_ready   (rsp_chan.ready),
      .rsp_payload (rsp_chan.payload)
   );

endmodule

// ----- sv/fcp_front.sv -----
// Front end: template parse state machine, one byte per accepted item.
// Depends on fcp_pkg; pushes classified entries into fcp_queue.
module fcp_front #(
   parameter int MAX_FIELD_LEN = fcp_pkg::MAX_FIELD_LEN_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        data_byte,
   input  logic              final_byte,
   output logic              push,
   output fcp_pkg::entry_type entry
);
   import fcp_pkg::*;

   localparam logic [7:0] MAX_LEN = 8'(MAX_FIELD_LEN);

   phase_type  phase_ff, phase_in;
   field_type  field_sel_ff, field_sel_in;
   logic [4:0] bytes_left_ff, bytes_left_in;
   logic [4:0] byte_pos_ff, byte_pos_in;

   lookup_type lk;
   logic       do_stat;
   cause_type  cause;
   logic       len_ok;
   logic       last;
   logic [7:0] limit;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_OUTER_TAG;
         field_sel_ff  <= FLD_SIZE;
         bytes_left_ff <= '0;
         byte_pos_ff   <= '0;
      end else if (accept) begin
         phase_ff      <= phase_in;
         field_sel_ff  <= field_sel_in;
         bytes_left_ff <= bytes_left_in;
         byte_pos_ff   <= byte_pos_in;
      end
   end

   always_comb begin
      phase_in      = phase_ff;
      field_sel_in  = field_sel_ff;
      bytes_left_in = bytes_left_ff;
      byte_pos_in   = byte_pos_ff;
      entry         = '0;
      do_stat       = 1'b0;
      cause         = CAUSE_NONE;
      lk            = tag_lookup(data_byte);
      limit         = rule_limit(field_sel_ff, MAX_LEN);
      len_ok        = rule_exact(field_sel_ff) ? (data_byte == limit) : (data_byte <= limit);
      last          = (bytes_left_ff <= 5'd1);

      case (phase_ff)
         PH_OUTER_TAG: begin
            if (data_byte != OUTER_TAG) begin
               do_stat = 1'b1;
               cause   = CAUSE_OUTER;
            end else if (final_byte) begin
               do_stat = 1'b1;
               cause   = CAUSE_TRUNC;
            end else begin
               phase_in = PH_OUTER_LEN;
            end
         end
         PH_OUTER_LEN: begin
            if (final_byte) begin
               do_stat = 1'b1;
            end else begin
               phase_in = PH_TAG;
            end
         end
         PH_TAG: begin
            if (!lk.found) begin
               do_stat = 1'b1;
               cause   = CAUSE_TAG;
            end else if (final_byte) begin
               do_stat = 1'b1;
               cause   = CAUSE_TRUNC;
            end else begin
               field_sel_in = lk.code;
               phase_in     = PH_LEN;
            end
         end
         PH_LEN: begin
            if (!len_ok) begin
               do_stat = 1'b1;
               cause   = CAUSE_LEN;
            end else if (data_byte == 8'd0) begin
               if (final_byte) do_stat = 1'b1;
               else phase_in = PH_TAG;
            end else if (final_byte) begin
               do_stat = 1'b1;
               cause   = CAUSE_TRUNC;
            end else begin
               bytes_left_in = data_byte[4:0];
               byte_pos_in   = '0;
               phase_in      = PH_VALUE;
            end
         end
         PH_VALUE: begin
            entry.has_val    = 1'b1;
            entry.field_code = field_sel_ff;
            entry.value      = data_byte;
            entry.offset     = byte_pos_ff;
            entry.field_end  = last;
            byte_pos_in      = byte_pos_ff + 5'd1;
            bytes_left_in    = last ? 5'd0 : bytes_left_ff - 5'd1;
            if (last) begin
               phase_in = PH_TAG;
               if (final_byte) do_stat = 1'b1;
            end else if (final_byte) begin
               do_stat = 1'b1;
               cause   = CAUSE_TRUNC;
            end
         end
         default: begin
            // dropping after an error, until the final byte
            if (final_byte) phase_in = PH_OUTER_TAG;
         end
      endcase

      if (do_stat) begin
         entry.has_stat = 1'b1;
         entry.cause    = cause;
         if (cause != CAUSE_NONE && !final_byte) begin
            phase_in = PH_DROP;
         end else begin
            phase_in      = PH_OUTER_TAG;
            field_sel_in  = FLD_SIZE;
            bytes_left_in = '0;
            byte_pos_in   = '0;
         end
      end

      push = accept && (entry.has_val || entry.has_stat);
   end

endmodule

// ----- sv/fcp_queue.sv -----
// Short FIFO of parsed entries between front end and result sequencer.
// Depends on fcp_pkg and the assertion macro header.
module fcp_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  fcp_pkg::entry_type push_data,
   input  logic               pop,
   output logic               full,
   output logic               not_empty,
   output fcp_pkg::entry_type head
);
   import fcp_pkg::*;
   `include "fcp_tlv_parser_core_assert.svh"

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

   entry_type       slots_ff [QUEUE_DEPTH];
   logic [AW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]   count_ff, count_in;

   always_ff @(posedge clock) begin
      if (push) slots_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (!push && pop) count_in = count_ff - 1'b1;
   end

   assign full      = (count_ff == DEPTH_C);
   assign not_empty = (count_ff != '0);
   assign head      = slots_ff[rd_ptr_ff];

   `FCP_ASSERT_IMP(a_q_bound, 1'b1, count_ff <= DEPTH_C, "queue count over depth")
   `FCP_ASSERT_IMP(a_q_no_underflow, pop, not_empty, "pop from empty queue")
   `FCP_ASSERT_IMP(a_q_no_overflow, push && !pop, !full, "push into full queue")
   `FCP_ASSERT_NXT(a_q_count, push && !pop, count_ff == $past(count_ff) + 1'b1,
                   "queue count did not advance on push")

endmodule

// ----- sv/fcp_back.sv -----
// Result sequencer: expands queued entries into one or two result items.
// Depends on fcp_pkg and the assertion macro header.
module fcp_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_not_empty,
   input  fcp_pkg::entry_type q_head,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output fcp_pkg::rsp_type   rsp_payload
);
   import fcp_pkg::*;
   `include "fcp_tlv_parser_core_assert.svh"

   entry_type ent_ff, ent_in;
   logic      ent_valid_ff, ent_valid_in;
   logic      val_done_ff, val_done_in;
   logic      take;
   logic      second;

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_valid_ff <= 1'b0;
         val_done_ff  <= 1'b0;
      end else begin
         ent_valid_ff <= ent_valid_in;
         val_done_ff  <= val_done_in;
      end
      ent_ff <= ent_in;
   end

   always_comb begin
      take         = ent_valid_ff && rsp_ready;
      // value result showing now, with a status still to follow
      second       = ent_ff.has_val && ent_ff.has_stat && !val_done_ff;
      ent_in       = ent_ff;
      ent_valid_in = ent_valid_ff;
      val_done_in  = val_done_ff;
      q_pop        = 1'b0;
      if (take && second) begin
         val_done_in = 1'b1;
      end else if (take || !ent_valid_ff) begin
         q_pop        = q_not_empty;
         ent_valid_in = q_not_empty;
         ent_in       = q_head;
         val_done_in  = 1'b0;
      end

      rsp_payload = '0;
      if (ent_ff.has_val && !val_done_ff) begin
         rsp_payload.kind       = KIND_VALUE;
         rsp_payload.field_code = ent_ff.field_code;
         rsp_payload.value      = ent_ff.value;
         rsp_payload.offset     = ent_ff.offset;
         rsp_payload.field_end  = ent_ff.field_end;
         rsp_payload.run_last   = !ent_ff.has_stat;
      end else begin
         rsp_payload.kind        = (ent_ff.cause == CAUSE_NONE) ? KIND_OK : KIND_FAIL;
         rsp_payload.error_cause = ent_ff.cause;
         rsp_payload.run_last    = 1'b1;
      end
   end

   assign rsp_valid = ent_valid_ff;

   `FCP_ASSERT_IMP(a_b_done_pair, val_done_ff,
                   ent_valid_ff && ent_ff.has_val && ent_ff.has_stat,
                   "value marked sent on an entry without a pending status")
   `FCP_ASSERT_IMP(a_b_nonempty, ent_valid_ff, ent_ff.has_val || ent_ff.has_stat,
                   "entry with no results held")
   `FCP_ASSERT_NXT(a_b_pair_order, take && second, ent_valid_ff && val_done_ff,
                   "status of a two-result entry lost")

endmodule
